// File: design/rgbg_pkg.sv
`timescale 1ns / 1ps

package rgbg_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_QUALITY_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_ENABLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCANLINE_ENABLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH         = 3'd5;

  localparam logic [1:0] MODE_FAST  = 2'd0;
  localparam logic [1:0] MODE_BT601 = 2'd1;
  localparam logic [1:0] MODE_BT709 = 2'd2;

  localparam logic [15:0] W_FAST_R  = 16'd64;
  localparam logic [15:0] W_FAST_G  = 16'd128;
  localparam logic [15:0] W_FAST_B  = 16'd32;
  localparam logic [15:0] W_601_R   = 16'd77;
  localparam logic [15:0] W_601_G   = 16'd150;
  localparam logic [15:0] W_601_B   = 16'd29;
  localparam logic [15:0] W_709_R   = 16'd13933;
  localparam logic [15:0] W_709_G   = 16'd46871;
  localparam logic [15:0] W_709_B   = 16'd4732;

  // floor(17v/20) for v in 0..255
  localparam logic [15:0] SCAN_MULT = 16'd55706;

  localparam logic [7:0]  GRAY_MAX  = 8'd255;

  localparam logic [12:0] ROW_WIDTH_RESET = 13'd640;

  typedef struct packed {
    logic [1:0]        quality_mode;
    logic signed [8:0] brightness_offset;
    logic signed [8:0] threshold_level;
    logic              invert_enable;
    logic              scanline_enable;
    logic [12:0]       row_width;
  } cfg_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       even_col;
  } luma_word_t;

endpackage

// File: design/rgbg_cfg.sv
`timescale 1ns / 1ps

module rgbg_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rgbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rgbg_pkg::cfg_t                  cfg
);

  rgbg_pkg::cfg_t cfg_r;
  rgbg_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rgbg_pkg::REG_QUALITY_MODE:      cfg_nxt.quality_mode      = cfg_wdata[1:0];
        rgbg_pkg::REG_BRIGHTNESS_OFFSET: cfg_nxt.brightness_offset = cfg_wdata[8:0];
        rgbg_pkg::REG_THRESHOLD_LEVEL:   cfg_nxt.threshold_level   = cfg_wdata[8:0];
        rgbg_pkg::REG_INVERT_ENABLE:     cfg_nxt.invert_enable     = cfg_wdata[0];
        rgbg_pkg::REG_SCANLINE_ENABLE:   cfg_nxt.scanline_enable   = cfg_wdata[0];
        rgbg_pkg::REG_ROW_WIDTH:         cfg_nxt.row_width         = cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quality_mode      <= rgbg_pkg::MODE_BT601;
      cfg_r.brightness_offset <= 9'sd0;
      cfg_r.threshold_level   <= -9'sd1;
      cfg_r.invert_enable     <= 1'b0;
      cfg_r.scanline_enable   <= 1'b0;
      cfg_r.row_width         <= rgbg_pkg::ROW_WIDTH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/rgbg_luma.sv
`timescale 1ns / 1ps

module rgbg_luma #(
  parameter int unsigned MAX_ROW_WIDTH = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rgbg_pkg::cfg_t          cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_red,
  input  logic [7:0]              in_green,
  input  logic [7:0]              in_blue,
  input  logic                    in_frame_start,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output rgbg_pkg::luma_word_t    dn_word
);

  localparam int unsigned CW   = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int unsigned CMPW = (CW + 1 > 13) ? CW + 1 : 13;
  localparam logic [CMPW-1:0] MAXW = CMPW'(MAX_ROW_WIDTH);

  logic [CW-1:0]        col_r;
  logic [CW-1:0]        col_nxt;
  logic [CW-1:0]        col_cur;
  logic [CMPW-1:0]      col_inc;
  logic [CMPW-1:0]      rw_ext;
  logic [CMPW-1:0]      eff_w;

  logic                 s1_valid_r;
  logic [7:0]           s1_red_r;
  logic [7:0]           s1_green_r;
  logic [7:0]           s1_blue_r;
  logic                 s1_even_r;

  logic                 s2_valid_r;
  rgbg_pkg::luma_word_t s2_word_r;
  rgbg_pkg::luma_word_t s2_word_nxt;

  logic                 rdy1;
  logic                 rdy2;
  logic                 accept;

  logic [15:0]          wr;
  logic [15:0]          wg;
  logic [15:0]          wb;
  logic [23:0]          sum;
  logic [15:0]          shifted;

  assign rdy2     = !s2_valid_r || dn_ready;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_ready = rdy1;
  assign accept   = in_valid && rdy1;

  // column tracking
  always_comb begin
    col_cur = in_frame_start ? '0 : col_r;
    col_inc = CMPW'(col_cur) + CMPW'(1);
    rw_ext  = CMPW'(cfg.row_width);
    if (cfg.row_width == 13'd0) begin
      eff_w = CMPW'(1);
    end else if (rw_ext > MAXW) begin
      eff_w = MAXW;
    end else begin
      eff_w = rw_ext;
    end
    col_nxt = (col_inc >= eff_w) ? '0 : col_inc[CW-1:0];
  end

  // weighted sum
  always_comb begin
    unique case (cfg.quality_mode)
      rgbg_pkg::MODE_FAST: begin
        wr = rgbg_pkg::W_FAST_R;
        wg = rgbg_pkg::W_FAST_G;
        wb = rgbg_pkg::W_FAST_B;
      end
      rgbg_pkg::MODE_BT709: begin
        wr = rgbg_pkg::W_709_R;
        wg = rgbg_pkg::W_709_G;
        wb = rgbg_pkg::W_709_B;
      end
      default: begin
        wr = rgbg_pkg::W_601_R;
        wg = rgbg_pkg::W_601_G;
        wb = rgbg_pkg::W_601_B;
      end
    endcase
    sum = 24'(s1_red_r) * 24'(wr) + 24'(s1_green_r) * 24'(wg) + 24'(s1_blue_r) * 24'(wb);
    if (cfg.quality_mode == rgbg_pkg::MODE_BT709) begin
      shifted = {8'd0, sum[23:16]};
    end else begin
      shifted = sum[23:8];
    end
    s2_word_nxt.luma     = (shifted > 16'd255) ? rgbg_pkg::GRAY_MAX : shifted[7:0];
    s2_word_nxt.even_col = s1_even_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid_r <= in_valid;
      end
      if (accept) begin
        col_r <= col_nxt;
      end
      if (rdy2) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
      s1_even_r  <= ~col_cur[0];
    end
    if (rdy2 && s1_valid_r) begin
      s2_word_r <= s2_word_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_word  = s2_word_r;

endmodule

// File: design/rgbg_tone.sv
`timescale 1ns / 1ps

module rgbg_tone (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rgbg_pkg::cfg_t       cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  rgbg_pkg::luma_word_t up_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_gray
);

  logic              out_valid_r;
  logic [7:0]        out_gray_r;
  logic [7:0]        gray_nxt;

  logic signed [9:0] bsum;
  logic [7:0]        clamped;
  logic [7:0]        thr;
  logic [7:0]        inv;
  logic [23:0]       scan_prod;

  assign up_ready = !out_valid_r || out_ready;

  always_comb begin
    bsum = $signed({2'b00, up_word.luma}) + 10'(cfg.brightness_offset);
    if (bsum < 10'sd0) begin
      clamped = 8'd0;
    end else if (bsum > 10'sd255) begin
      clamped = rgbg_pkg::GRAY_MAX;
    end else begin
      clamped = bsum[7:0];
    end
    // negative level disables binarization
    if (!cfg.threshold_level[8]) begin
      thr = (clamped >= cfg.threshold_level[7:0]) ? rgbg_pkg::GRAY_MAX : 8'd0;
    end else begin
      thr = clamped;
    end
    inv       = cfg.invert_enable ? (rgbg_pkg::GRAY_MAX - thr) : thr;
    scan_prod = 24'(inv) * 24'(rgbg_pkg::SCAN_MULT);
    gray_nxt  = (cfg.scanline_enable && up_word.even_col) ? scan_prod[23:16] : inv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      out_gray_r <= gray_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_gray  = out_gray_r;

endmodule

// File: design/rgb_to_gray_pixel_pipeline_top.sv
`timescale 1ns / 1ps

// Channel | Ports                     | Word layout (lsb first)
// --------+---------------------------+----------------------------------
// input   | in_tvalid/tready/tdata/tuser | tdata: red, green, blue; tuser: frame_start
// output  | out_tvalid/tready/tdata   | tdata: gray
// config  | cfg_we/cfg_index/cfg_wdata | index 0..5, write-only
//
// One word per clock sustained while out_tready stays high. An accepted word is held in
// turn by the input register, the weighted-sum register and the output register, which
// drives out_tvalid and out_tdata.
// Reset (rst_n low, synchronous) empties the pipe, loads register defaults and clears
// the column counter. Each stage advances when the one after it is empty or draining,
// so out_tready low stalls only as far back as the pipe is full.

module rgb_to_gray_pixel_pipeline_top #(
  parameter int unsigned MAX_ROW_WIDTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // red, green, blue
  input  logic [0:0]                      in_tuser,   // frame_start
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // gray
  input  logic                            cfg_we,
  input  logic [rgbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rgbg_pkg::cfg_t       cfg;
  logic                 mid_valid;
  logic                 mid_ready;
  rgbg_pkg::luma_word_t mid_word;

  rgbg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rgbg_luma #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_luma (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_red         (in_tdata[7:0]),
    .in_green       (in_tdata[15:8]),
    .in_blue        (in_tdata[23:16]),
    .in_frame_start (in_tuser[0]),
    .dn_valid       (mid_valid),
    .dn_ready       (mid_ready),
    .dn_word        (mid_word)
  );

  rgbg_tone u_tone (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .up_valid  (mid_valid),
    .up_ready  (mid_ready),
    .up_word   (mid_word),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_gray  (out_tdata)
  );

endmodule

// File: tb/tb_rgb_to_gray_pixel_pipeline_top.sv
`timescale 1ns / 1ps

module tb_rgb_to_gray_pixel_pipeline_top;

  localparam int unsigned MAX_W       = 4096;
  localparam int          PIPE_LAT    = 3;
  localparam int          HOLD_LEN    = 300;
  localparam int          STALL_LIMIT = 3000;
  localparam int          RAND_PHASES = 30;
  localparam int          PHASE_ITEMS = 26;

  localparam logic [1:0]                     MODE_SPARE  = 2'd3;
  localparam logic [rgbg_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [rgbg_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic       fs;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [23:0]                     in_tdata   = '0;
  logic [0:0]                      in_tuser   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [7:0]                      out_tdata;
  logic                            cfg_we     = 1'b0;
  logic [rgbg_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [rgbg_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  rgb_to_gray_pixel_pipeline_top #(.MAX_ROW_WIDTH(MAX_W)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // shadow of the block's registers and column counter
  logic [1:0]        m_mode   = rgbg_pkg::MODE_BT601;
  logic signed [8:0] m_offset = 9'sd0;
  logic signed [8:0] m_thresh = -9'sd1;
  logic              m_inv    = 1'b0;
  logic              m_scan   = 1'b0;
  logic [12:0]       m_width  = rgbg_pkg::ROW_WIDTH_RESET;
  int                m_col    = 0;

  pixel_t     pixel_q[$];
  logic [7:0] expected_gray_q[$];

  int n_pushed    = 0;
  int n_out       = 0;
  int n_err       = 0;
  int stall_cnt   = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_reqs   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  logic in_acc    = 1'b0;

  function automatic logic [7:0] predict_gray(logic [23:0] px, logic fs);
    int r, g, b, s, v, w;
    r = px[7:0];
    g = px[15:8];
    b = px[23:16];
    if (fs) m_col = 0;
    case (m_mode)
      rgbg_pkg::MODE_FAST:  s = (64 * r + 128 * g + 32 * b) >>> 8;
      rgbg_pkg::MODE_BT709: s = (13933 * r + 46871 * g + 4732 * b) >>> 16;
      default:              s = (77 * r + 150 * g + 29 * b) >>> 8;
    endcase
    if (s > 255) s = 255;
    v = s + int'(m_offset);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    if (int'(m_thresh) >= 0) v = (v >= int'(m_thresh)) ? 255 : 0;
    if (m_inv) v = 255 - v;
    if (m_scan && (m_col % 2 == 0)) v = (v * 55706) >>> 16;
    w = m_width;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    m_col = (m_col + 1 >= w) ? 0 : m_col + 1;
    return v[7:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_err++;
  endtask

  // driver: offers the next pending word once the previous one is taken
  always @(negedge clk) begin : drv
    pixel_t p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_acc) begin
      if (pixel_q.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        p = pixel_q.pop_front();
        in_tdata  <= {p.b, p.g, p.r};
        in_tuser  <= p.fs;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen  = hold_seen + 1;
      hold_left  = HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // monitor: predicts on input accept, checks on output accept
  always @(posedge clk) begin : mon
    logic [7:0] want;
    in_acc <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_out = n_out + 1;
        if (expected_gray_q.size() == 0) begin
          report_mismatch($sformatf("gray %0d with nothing pending", out_tdata));
        end else begin
          want = expected_gray_q.pop_front();
          if (out_tdata !== want)
            report_mismatch($sformatf("gray %0d, want %0d", out_tdata, want));
        end
      end
      if (in_tvalid && in_tready)
        expected_gray_q.push_back(predict_gray(in_tdata, in_tuser[0]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt = 0;
      else stall_cnt = stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
    pixel_t p;
    p.r = r;
    p.g = g;
    p.b = b;
    p.fs = fs;
    pixel_q.push_back(p);
    n_pushed++;
  endtask

  function automatic logic [7:0] rand_comp();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_random(int n);
    repeat (n) push_pixel(rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 39) == 0);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    while (n_out < n_pushed) @(negedge clk);
    repeat (PIPE_LAT + 2) @(negedge clk);
  endtask

  task automatic cfg_write(logic [rgbg_pkg::CFG_IDX_W-1:0] idx,
                           logic [rgbg_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      rgbg_pkg::REG_QUALITY_MODE:      m_mode   = val[1:0];
      rgbg_pkg::REG_BRIGHTNESS_OFFSET: m_offset = val[8:0];
      rgbg_pkg::REG_THRESHOLD_LEVEL:   m_thresh = val[8:0];
      rgbg_pkg::REG_INVERT_ENABLE:     m_inv    = val[0];
      rgbg_pkg::REG_SCANLINE_ENABLE:   m_scan   = val[0];
      rgbg_pkg::REG_ROW_WIDTH:         m_width  = val[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_setting(logic [1:0] mode, logic signed [8:0] off, logic signed [8:0] th,
                             logic inv, logic scan, logic [12:0] width, int n);
    cfg_write(rgbg_pkg::REG_QUALITY_MODE, {11'd0, mode});
    cfg_write(rgbg_pkg::REG_BRIGHTNESS_OFFSET, {{4{off[8]}}, off});
    cfg_write(rgbg_pkg::REG_THRESHOLD_LEVEL, {{4{th[8]}}, th});
    cfg_write(rgbg_pkg::REG_INVERT_ENABLE, {12'd0, inv});
    cfg_write(rgbg_pkg::REG_SCANLINE_ENABLE, {12'd0, scan});
    cfg_write(rgbg_pkg::REG_ROW_WIDTH, width);
    push_random(n);
    wait_drain();
  endtask

  function automatic logic [12:0] rand_width();
    case ($urandom_range(0, 9))
      0:       return 13'd0;
      1:       return 13'd640;
      2:       return 13'(MAX_W);
      3:       return 13'($urandom_range(MAX_W + 1, 8191));
      4:       return 13'($urandom_range(0, 8191));
      default: return 13'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic signed [8:0] rand_offset();
    case ($urandom_range(0, 5))
      0:       return 9'sd0;
      1:       return 9'sd255;
      2:       return -9'sd255;
      3:       return -9'sd256;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic signed [8:0] rand_thresh();
    case ($urandom_range(0, 5))
      0:       return -9'sd1;
      1:       return 9'($urandom_range(256, 511));
      2:       return 9'sd0;
      default: return 9'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    snd_idle_pct = 21;
    rcv_idle_pct = 52;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults after reset: corners of the pixel space
    push_pixel(8'd0,   8'd0,   8'd0,   1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    push_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    push_pixel(8'd0,   8'd0,   8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd0,   1'b0);
    push_pixel(8'd0,   8'd255, 8'd255, 1'b1);
    push_pixel(8'd255, 8'd0,   8'd255, 1'b0);
    push_pixel(8'd1,   8'd1,   8'd1,   1'b0);
    push_pixel(8'd254, 8'd254, 8'd254, 1'b0);
    push_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    push_pixel(8'd127, 8'd127, 8'd127, 1'b0);
    push_pixel(8'd170, 8'd85,  8'd170, 1'b0);
    push_pixel(8'd85,  8'd170, 8'd85,  1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    push_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    wait_drain();

    run_setting(rgbg_pkg::MODE_FAST,  9'sd0,    -9'sd1,   1'b0, 1'b0, 13'd640,  12);
    run_setting(rgbg_pkg::MODE_BT709, 9'sd0,    -9'sd1,   1'b0, 1'b0, 13'd640,  12);
    run_setting(MODE_SPARE,           9'sd0,    -9'sd1,   1'b0, 1'b0, 13'd640,  12);
    run_setting(rgbg_pkg::MODE_BT601, 9'sd255,  -9'sd1,   1'b0, 1'b0, 13'd640,  10);
    run_setting(rgbg_pkg::MODE_BT709, -9'sd255, -9'sd1,   1'b0, 1'b0, 13'd640,  10);
    run_setting(rgbg_pkg::MODE_FAST,  -9'sd256, -9'sd1,   1'b0, 1'b0, 13'd640,  10);
    run_setting(rgbg_pkg::MODE_BT601, 9'sd0,    9'sd0,    1'b0, 1'b0, 13'd640,  10);
    run_setting(rgbg_pkg::MODE_BT601, 9'sd0,    9'sd255,  1'b0, 1'b0, 13'd640,  10);
    run_setting(rgbg_pkg::MODE_BT709, 9'sd20,   9'sd128,  1'b1, 1'b0, 13'd640,  10);
    run_setting(rgbg_pkg::MODE_BT601, 9'sd0,    -9'sd256, 1'b1, 1'b0, 13'd640,  10);
    run_setting(rgbg_pkg::MODE_BT601, 9'sd0,    -9'sd1,   1'b0, 1'b1, 13'd0,    10);
    run_setting(rgbg_pkg::MODE_BT601, 9'sd0,    -9'sd1,   1'b0, 1'b1, 13'd1,    10);
    run_setting(rgbg_pkg::MODE_FAST,  9'sd0,    -9'sd1,   1'b1, 1'b1, 13'd2,    10);
    run_setting(rgbg_pkg::MODE_BT709, 9'sd0,    -9'sd1,   1'b0, 1'b1, 13'd3,    10);
    run_setting(rgbg_pkg::MODE_BT601, 9'sd0,    -9'sd1,   1'b0, 1'b1, 13'd4096, 10);
    run_setting(rgbg_pkg::MODE_BT601, 9'sd0,    -9'sd1,   1'b0, 1'b1, 13'd8191, 10);
    run_setting(rgbg_pkg::MODE_BT601, 9'sd0,    -9'sd1,   1'b0, 1'b1, 13'd640,  25);
    // width lowered below the current column
    run_setting(rgbg_pkg::MODE_BT601, 9'sd0,    -9'sd1,   1'b0, 1'b1, 13'd4,    10);
    cfg_write(REG_SPARE_6, 13'h1FFF);
    cfg_write(REG_SPARE_7, 13'h0AAA);
    push_random(10);
    wait_drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES / 3) begin
        snd_idle_pct = 52;
        rcv_idle_pct = 21;
      end else if (ph == 2 * RAND_PHASES / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      run_setting(2'($urandom_range(0, 3)), rand_offset(), rand_thresh(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_width(), 0);
      if (ph == 5 || ph == 25) hold_reqs++;
      if (ph == 15) begin
        push_random(PHASE_ITEMS / 2);
        wait_drain();
        push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        push_random(PHASE_ITEMS);
      end
      wait_drain();
    end

    repeat (20) @(negedge clk);
    if (expected_gray_q.size() != 0)
      report_mismatch($sformatf("%0d results never came", expected_gray_q.size()));
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
